FILE: src/desrnd_pkg.sv
// Permutation, expansion and substitution tables for one DES round, plus the
// functions that apply them. No dependencies; used by des_ip_and_round_single_sbox_top.
`default_nettype none

package desrnd_pkg;

	localparam logic [6:0] IP_TAB [64] = '{
		7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
		7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
		7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
		7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
		7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
		7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
		7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
		7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
	};

	localparam logic [5:0] E_TAB [48] = '{
		6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,
		6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
		6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13,
		6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
		6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
		6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
		6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
		6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
	};

	// indexed by {row, column}
	localparam logic [3:0] S1_TAB [64] = '{
		4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
		4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7,
		4'd0,  4'd15, 4'd7,  4'd4,  4'd14, 4'd2,  4'd13, 4'd1,
		4'd10, 4'd6,  4'd12, 4'd11, 4'd9,  4'd5,  4'd3,  4'd8,
		4'd4,  4'd1,  4'd14, 4'd8,  4'd13, 4'd6,  4'd2,  4'd11,
		4'd15, 4'd12, 4'd9,  4'd7,  4'd3,  4'd10, 4'd5,  4'd0,
		4'd15, 4'd12, 4'd8,  4'd2,  4'd4,  4'd9,  4'd1,  4'd7,
		4'd5,  4'd11, 4'd3,  4'd14, 4'd10, 4'd0,  4'd6,  4'd13
	};

	localparam logic [5:0] P_TAB [32] = '{
		6'd16, 6'd7,  6'd20, 6'd21,
		6'd29, 6'd12, 6'd28, 6'd17,
		6'd1,  6'd15, 6'd23, 6'd26,
		6'd5,  6'd18, 6'd31, 6'd10,
		6'd2,  6'd8,  6'd24, 6'd14,
		6'd32, 6'd27, 6'd3,  6'd9,
		6'd19, 6'd13, 6'd30, 6'd6,
		6'd22, 6'd11, 6'd4,  6'd25
	};

	// table entries number bits from the MSB, starting at 1
	function automatic logic [63:0] ip_perm(input logic [63:0] v);
		logic [63:0] r;
		for (int i = 0; i < 64; i++) begin
			r[63 - i] = v[6'(64 - int'(IP_TAB[i]))];
		end
		return r;
	endfunction

	function automatic logic [47:0] e_expand(input logic [31:0] v);
		logic [47:0] r;
		for (int i = 0; i < 48; i++) begin
			r[47 - i] = v[5'(32 - int'(E_TAB[i]))];
		end
		return r;
	endfunction

	function automatic logic [31:0] s1_subst(input logic [47:0] x);
		logic [31:0] s;
		logic [5:0]  g;
		for (int i = 0; i < 8; i++) begin
			g = x[47 - 6 * i -: 6];
			s[31 - 4 * i -: 4] = S1_TAB[{g[5], g[0], g[4:1]}];
		end
		return s;
	endfunction

	function automatic logic [31:0] p_perm(input logic [31:0] v);
		logic [31:0] r;
		for (int i = 0; i < 32; i++) begin
			r[31 - i] = v[5'(32 - int'(P_TAB[i]))];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: src/des_ip_and_round_single_sbox_top.sv
// Top level: DES initial permutation and one Feistel round using S1 in every position.
// Depends on desrnd_pkg for the tables and round functions.
//
//   channel   dir   handshake            payload
//   s_*       in    s_tvalid/s_tready    s_tdata[63:0] plain_block
//   m_*       out   m_tvalid/m_tready    m_tdata[31:0] new_left, [63:32] new_right
//   cfg       in    round_key_we         round_key_wdata[47:0] round_key
//
// One block per cycle while m_tready is high; path: input register, result register.
// The round logic sits between the input register and the result register.
// arst_n clears both valid flags and the round key.
// A stalled result holds in the result register; one more block is taken into the
// input register behind it, then s_tready drops until m_tready returns.
`default_nettype none

module des_ip_and_round_single_sbox_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // [63:0] plain_block
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // [31:0] new_left, [63:32] new_right
	input  wire logic        round_key_we,
	input  wire logic [47:0] round_key_wdata
);

	logic [47:0] round_key_q;
	logic        valid_s1;
	logic [63:0] block_s1;
	logic        valid_s2;
	logic [63:0] result_s2;
	logic        adv_s1;

	logic [63:0] permuted;
	logic [31:0] left_half;
	logic [31:0] right_half;
	logic [31:0] f_out;

	assign adv_s1   = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s1;
	assign m_tvalid = valid_s2;
	assign m_tdata  = result_s2;

	always_comb begin
		permuted   = desrnd_pkg::ip_perm(block_s1);
		left_half  = permuted[63:32];
		right_half = permuted[31:0];
		f_out      = desrnd_pkg::p_perm(desrnd_pkg::s1_subst(
			desrnd_pkg::e_expand(right_half) ^ round_key_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_key_q <= '0;
		end else if (round_key_we) begin
			round_key_q <= round_key_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			block_s1 <= s_tdata;
		end
		if (adv_s1 && valid_s1) begin
			result_s2 <= {left_half ^ f_out, right_half};
		end
	end

	a_sink_ready_frees_source: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("s_tready low while m_tready high");

	a_full_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !m_tready) |-> !s_tready)
		else $error("input taken while both stages full and stalled");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> valid_s1)
		else $error("accepted block lost from input register");

	a_advance_fills_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s1) |=> m_tvalid)
		else $error("advanced block did not reach result register");

endmodule

`default_nettype wire
